// ----- hw/rtl/lse_pkg.sv -----
package lse_pkg;

  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] CfgMode      = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgDirection = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgWhiteMin  = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgHeaderLen = 4'd3;

  localparam logic [1:0] ModeLsb1 = 2'd0;
  localparam logic [1:0] ModeLsb4 = 2'd1;
  localparam logic [1:0] ModeLsbe = 2'd2;

  localparam logic DirHide    = 1'b0;
  localparam logic DirRecover = 1'b1;

  localparam logic [7:0] WhiteMinReset  = 8'd254;
  localparam logic [7:0] HeaderLenReset = 8'd54;

  localparam logic [7:0] HighNibbleMask = 8'hF0;
  localparam logic [7:0] LowNibbleMask  = 8'h0F;
  localparam logic [7:0] ClearLsbMask   = 8'hFE;

  typedef struct packed {
    logic [7:0] carrier_byte;
    logic [7:0] secret_byte;
    logic       payload_active;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       slot_used;
    logic       byte_done;
    logic [7:0] recovered_byte;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       direction;
    logic [7:0] white_min;
    logic [7:0] header_len;
  } cfg_t;

endpackage

// ----- hw/rtl/lsb_stego_embed_extract_top.sv -----
// lsb steganography embed / extract engine, one carrier byte per item.
// input channel: in_valid_i / in_stall_o with in_item_i (carrier byte, secret
// byte, payload flag, file start flag). output channel: out_valid_o /
// out_stall_i with out_item_o (carrier after embedding, slot flag, byte done
// flag, recovered byte). an item moves when valid is high and stall is low.
// configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// ready is always high, writes are meant for when the block is idle.
// an accepted item passes the input register, then the result register,
// before it is on out_valid_o. throughput: one item per cycle while the
// receiver does not stall, set by the single combinational pass between
// the two registers that also updates the header, slot and gather
// counters.
// when the receiver stalls, the result register holds; the input register
// fills and then in_stall_o rises the same cycle, so no item is lost.
// reset clears both pipeline valids, loads mode 0, hide direction,
// white_min 254, header_len 54 and a header count of 54 into the counters.
module lsb_stego_embed_extract_top
  import lse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res_q, res;
  logic      res_vld_q;
  logic      res_ready, in_ready, step;

  lse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign res_ready = !res_vld_q || !out_stall_i;
  assign step      = in_vld_q && res_ready;
  assign in_ready  = !in_vld_q || res_ready;
  assign in_stall_o = !in_ready;

  lse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_valid_i;
      end
      if (res_ready) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

endmodule

// ----- hw/rtl/lse_cfg_regs.sv -----
module lse_cfg_regs
  import lse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMode:      cfg_d.mode       = cfg_data_i[1:0];
        CfgDirection: cfg_d.direction  = cfg_data_i[0];
        CfgWhiteMin:  cfg_d.white_min  = cfg_data_i;
        CfgHeaderLen: cfg_d.header_len = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= ModeLsb1;
      cfg_q.direction  <= DirHide;
      cfg_q.white_min  <= WhiteMinReset;
      cfg_q.header_len <= HeaderLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/lse_core.sv -----
module lse_core
  import lse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [7:0] header_left_q, header_left_d;
  logic [2:0] slot_q, slot_d;
  logic [7:0] acc_q, acc_d;

  logic [7:0] hl, acc;
  logic [2:0] slot;
  logic       nibble_mode, take, done;
  logic [3:0] nib;
  logic       sbit;

  always_comb begin
    // file start reloads the header count and restarts the slot sequence
    hl   = item_i.file_start ? cfg_i.header_len : header_left_q;
    slot = item_i.file_start ? 3'd0 : slot_q;
    acc  = item_i.file_start ? 8'd0 : acc_q;

    nibble_mode = (cfg_i.mode == ModeLsb4);
    take = nibble_mode || (cfg_i.mode == ModeLsb1) ||
           (item_i.carrier_byte >= cfg_i.white_min);
    nib  = slot[0] ? item_i.secret_byte[3:0] : item_i.secret_byte[7:4];
    sbit = item_i.secret_byte[3'd7 - slot];

    header_left_d = hl;
    slot_d        = slot;
    acc_d         = acc;
    done          = 1'b0;

    result_o.out_byte       = item_i.carrier_byte;
    result_o.slot_used      = 1'b0;
    result_o.byte_done      = 1'b0;
    result_o.recovered_byte = 8'd0;

    if (hl != 8'd0) begin
      header_left_d = hl - 8'd1;
    end else if (item_i.payload_active && take) begin
      result_o.slot_used = 1'b1;
      if (nibble_mode) begin
        if (cfg_i.direction == DirHide) begin
          result_o.out_byte = (item_i.carrier_byte & HighNibbleMask) | {4'd0, nib};
        end else begin
          acc_d = {acc[3:0], 4'd0} | (item_i.carrier_byte & LowNibbleMask);
        end
        done   = slot[0];
        slot_d = slot[0] ? 3'd0 : 3'd1;
      end else begin
        if (cfg_i.direction == DirHide) begin
          result_o.out_byte = (item_i.carrier_byte & ClearLsbMask) | {7'd0, sbit};
        end else begin
          acc_d = {acc[6:0], item_i.carrier_byte[0]};
        end
        done   = (slot == 3'd7);
        slot_d = slot + 3'd1;
      end
      result_o.byte_done = done;
      if (done) begin
        if (cfg_i.direction == DirRecover) begin
          result_o.recovered_byte = acc_d;
        end
        acc_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_left_q <= HeaderLenReset;
      slot_q        <= 3'd0;
      acc_q         <= 8'd0;
    end else if (step_i) begin
      header_left_q <= header_left_d;
      slot_q        <= slot_d;
      acc_q         <= acc_d;
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lse_pkg::*;

  // expected results of the embed / extract engine, kept in order of acceptance
  class stego_scoreboard;
    cfg_t regs;
    logic [7:0] header_left;
    logic [2:0] slot_index;
    logic [7:0] gather_acc;
    out_item_t expected_outs[$];
    int errors;

    function new();
      regs.mode = ModeLsb1;
      regs.direction = DirHide;
      regs.white_min = WhiteMinReset;
      regs.header_len = HeaderLenReset;
      header_left = HeaderLenReset;
      slot_index = '0;
      gather_acc = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      case (idx)
        CfgMode: regs.mode = data[1:0];
        CfgDirection: regs.direction = data[0];
        CfgWhiteMin: regs.white_min = data;
        CfgHeaderLen: regs.header_len = data;
        default: ;
      endcase
    endfunction

    // works out the result of one carrier item and advances the counters
    function void note_carrier(in_item_t it);
      out_item_t want;
      logic take;
      logic done;
      logic [3:0] nib;
      logic [2:0] bitpos;
      want.out_byte = it.carrier_byte;
      want.slot_used = 1'b0;
      want.byte_done = 1'b0;
      want.recovered_byte = 8'h00;
      done = 1'b0;
      if (it.file_start) begin
        header_left = regs.header_len;
        slot_index = '0;
        gather_acc = '0;
      end
      if (header_left != 8'd0) begin
        header_left = header_left - 8'd1;
      end else if (it.payload_active) begin
        // mode three falls into the white threshold test like lsbe
        take = (regs.mode == ModeLsb1) || (regs.mode == ModeLsb4) ||
               (it.carrier_byte >= regs.white_min);
        if (take) begin
          want.slot_used = 1'b1;
          if (regs.mode == ModeLsb4) begin
            // only bit 0 of the slot picks the nibble
            nib = slot_index[0] ? it.secret_byte[3:0] : it.secret_byte[7:4];
            if (regs.direction == DirHide) begin
              want.out_byte = (it.carrier_byte & HighNibbleMask) | {4'h0, nib};
            end else begin
              gather_acc = {gather_acc[3:0], it.carrier_byte[3:0]};
            end
            if (slot_index[0]) begin
              done = 1'b1;
              slot_index = '0;
            end else begin
              slot_index = 3'd1;
            end
          end else begin
            bitpos = 3'd7 - slot_index;
            if (regs.direction == DirHide) begin
              want.out_byte = (it.carrier_byte & ClearLsbMask) |
                              {7'h00, it.secret_byte[bitpos]};
            end else begin
              gather_acc = {gather_acc[6:0], it.carrier_byte[0]};
            end
            if (slot_index == 3'd7) begin
              done = 1'b1;
              slot_index = '0;
            end else begin
              slot_index = slot_index + 3'd1;
            end
          end
          if (done && regs.direction == DirRecover) begin
            want.recovered_byte = gather_acc;
          end
          if (done) begin
            gather_acc = '0;
          end
        end
      end
      want.byte_done = done;
      expected_outs.push_back(want);
    endfunction

    function void check_out(out_item_t got);
      out_item_t want;
      if (expected_outs.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_outs.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.slot_used !== want.slot_used) begin
        $error("slot_used: expected %b, got %b", want.slot_used, got.slot_used);
        errors++;
      end
      if (got.byte_done !== want.byte_done) begin
        $error("byte_done: expected %b, got %b", want.byte_done, got.byte_done);
        errors++;
      end
      if (got.recovered_byte !== want.recovered_byte) begin
        $error("recovered_byte: expected %02h, got %02h", want.recovered_byte,
               got.recovered_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  bit idle_on = 1'b0;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  stego_scoreboard sb = new();

  lsb_stego_embed_extract_top DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o(out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_out(out_item);
      end
      if (in_valid && !in_stall) begin
        sb.note_carrier(in_item);
      end
    end
  end

  function automatic in_item_t carrier_item(logic [7:0] c, logic [7:0] s, logic a, logic f);
    in_item_t it;
    it.carrier_byte = c;
    it.secret_byte = s;
    it.payload_active = a;
    it.file_start = f;
    return it;
  endfunction

  task automatic send_carrier(in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // holds cfg_valid high across back to back writes; the caller lowers it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic configure(logic [1:0] m, logic d, logic [7:0] w, logic [7:0] h, bit junk);
    logic [7:0] hi;
    logic [CfgIdxW-1:0] bad_idx;
    hi = 8'($urandom);
    bad_idx = CfgIdxW'($urandom_range(4, 15));
    // upper bits of the narrow registers carry noise
    write_reg(CfgMode, {hi[7:2], m});
    write_reg(CfgDirection, {hi[7:1], d});
    write_reg(CfgWhiteMin, w);
    write_reg(CfgHeaderLen, h);
    if (junk) begin
      write_reg(bad_idx, hi);
    end
    cfg_valid <= 1'b0;
  endtask

  // waits on the clock first so the last accepted item is already on the scoreboard
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] m;
    logic d;
    logic [7:0] wmin;
    logic [7:0] hlen;
    logic [7:0] secret;
    in_item_t it;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header bytes under reset settings pass untouched
    send_carrier(carrier_item(8'hFF, 8'h00, 1'b1, 1'b0));
    send_carrier(carrier_item(8'h00, 8'hFF, 1'b1, 1'b0));
    drain();

    // one bit per byte, no header
    configure(ModeLsb1, DirHide, 8'd254, 8'd0, 1'b1);
    send_carrier(carrier_item(8'h00, 8'hA5, 1'b1, 1'b1));
    for (int k = 1; k < 8; k++) begin
      send_carrier(carrier_item((k % 2) ? 8'hFF : 8'h00, 8'hA5, 1'b1, 1'b0));
    end
    send_carrier(carrier_item(8'h5A, 8'hA5, 1'b0, 1'b0));
    drain();

    configure(ModeLsb4, DirRecover, 8'd254, 8'd0, 1'b0);
    send_carrier(carrier_item(8'hF3, 8'h00, 1'b1, 1'b1));
    send_carrier(carrier_item(8'h0C, 8'hFF, 1'b1, 1'b0));
    drain();

    configure(ModeLsb4, DirHide, 8'd0, 8'd0, 1'b0);
    send_carrier(carrier_item(8'hAB, 8'h5C, 1'b1, 1'b1));
    send_carrier(carrier_item(8'h50, 8'h5C, 1'b1, 1'b0));
    drain();

    // mode three acts like the white threshold mode
    configure(2'd3, DirHide, 8'd255, 8'd0, 1'b1);
    send_carrier(carrier_item(8'hFF, 8'h80, 1'b1, 1'b1));
    send_carrier(carrier_item(8'hFE, 8'h80, 1'b1, 1'b0));
    send_carrier(carrier_item(8'h00, 8'h80, 1'b1, 1'b0));
    drain();

    configure(ModeLsbe, DirRecover, 8'd0, 8'd255, 1'b0);
    send_carrier(carrier_item(8'h00, 8'h00, 1'b1, 1'b1));
    send_carrier(carrier_item(8'hFF, 8'hFF, 1'b1, 1'b0));

    while (items_sent < 820) begin
      drain();
      idle_on = (items_sent < 720) && ($urandom_range(0, 3) != 0);
      m = 2'($urandom_range(0, 3));
      d = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: wmin = 8'd0;
        1: wmin = 8'd255;
        default: wmin = 8'($urandom);
      endcase
      hlen = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      configure(m, d, wmin, hlen, $urandom_range(0, 3) == 0);
      n = $urandom_range(16, 64);
      secret = 8'($urandom);
      for (int k = 0; k < n; k++) begin
        // mostly one clean file per phase; sometimes it just continues mid byte
        it.file_start = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
        it.payload_active = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 9) == 0) begin
          secret = 8'($urandom);
        end
        it.secret_byte = secret;
        it.carrier_byte = $urandom_range(0, 1) ? 8'($urandom_range(wmin, 255)) : 8'($urandom);
        send_carrier(it);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
